// ===== sv/rws_pkg.sv =====
// Shared types, widths and defaults for the roulette wheel selector.
`default_nettype none

package rws_pkg;

   // Default sizing of the population table.
   localparam int POP_SIZE_DEF     = 32;
   localparam int FITNESS_BITS_DEF = 10;

   // Fixed field widths of the request and response beats.
   localparam int ENTRY_INDEX_W   = 5;
   localparam int FITNESS_VALUE_W = 10;
   localparam int RAND_POINT_W    = 15;
   localparam int TOTAL_W         = 15;

   // Largest total that the response can carry.
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = 15'h7FFF;

   // Request kinds.
   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_SELECT = 1'b1;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_WALK,
      ST_FINISH
   } rws_state_type;

endpackage

`default_nettype wire

// ===== sv/rws_if.sv =====
// Request and response channel interfaces of the roulette wheel selector.
`default_nettype none

interface rws_req_if import rws_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       req_type;
   logic [ENTRY_INDEX_W-1:0]   entry_index;
   logic [FITNESS_VALUE_W-1:0] fitness_value;
   logic [RAND_POINT_W-1:0]    rand_point;

   modport source (output valid, req_type, entry_index, fitness_value, rand_point,
                   input ready);
   modport sink   (input valid, req_type, entry_index, fitness_value, rand_point,
                   output ready);
endinterface

interface rws_rsp_if import rws_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [ENTRY_INDEX_W-1:0] selected_index;
   logic                     select_miss;
   logic [TOTAL_W-1:0]       total_fitness;
   logic                     goal_reached;

   modport source (output valid, selected_index, select_miss, total_fitness, goal_reached,
                   input ready);
   modport sink   (input valid, selected_index, select_miss, total_fitness, goal_reached,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/rws_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module rws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== sv/roulette_wheel_selector_top.sv =====
// Top level of the roulette wheel selector: fitness table, walk and response register.
//
// The block holds POP_SIZE fitness values in a RAM and answers one beat per request.
// A load (req_type 0) writes one entry and keeps the running total and the count of zero
// entries current. A select (req_type 1) walks the table from entry 0, one RAM read and
// one accumulate per cycle, and stops at the first entry whose cumulative interval holds
// the point. A point at or above the total returns the last index with select_miss set.
// Loads whose entry_index is at or beyond POP_SIZE leave the table unchanged. The table
// reads as zero after reset through one valid flag per entry, so no clearing pass is
// needed. The response sits in an output register, so a new request is taken while the
// previous response waits.
`default_nettype none

module roulette_wheel_selector_top import rws_pkg::*; #(
   parameter int POP_SIZE     = POP_SIZE_DEF,
   parameter int FITNESS_BITS = FITNESS_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   rws_req_if.sink   req_bus,
   rws_rsp_if.source rsp_bus
);

   localparam int IDX_W = $clog2(POP_SIZE);
   localparam int SUM_W = FITNESS_BITS + IDX_W;
   localparam int CMP_W = (SUM_W > RAND_POINT_W) ? SUM_W : RAND_POINT_W;
   localparam int ZC_W  = $clog2(POP_SIZE + 1);

   rws_state_type state_ff, state_in;

   logic [IDX_W-1:0]        cur_ff, cur_in;
   logic [IDX_W-1:0]        addr_ff, addr_in;
   logic [SUM_W-1:0]        start_ff, start_in;
   logic [RAND_POINT_W-1:0] point_ff, point_in;
   logic [FITNESS_BITS-1:0] fit_ff, fit_in;
   logic [IDX_W-1:0]        sel_ff, sel_in;
   logic                    miss_ff, miss_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [ZC_W-1:0]         zc_ff, zc_in;
   logic [POP_SIZE-1:0]     valid_ff, valid_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ENTRY_INDEX_W-1:0] rsp_sel_ff, rsp_sel_in;
   logic                     rsp_miss_ff, rsp_miss_in;
   logic [TOTAL_W-1:0]       rsp_total_ff, rsp_total_in;
   logic                     rsp_goal_ff, rsp_goal_in;

   logic                    ram_wr_en;
   logic [IDX_W-1:0]        ram_wr_addr;
   logic [FITNESS_BITS-1:0] ram_wr_data;
   logic                    ram_rd_en;
   logic [IDX_W-1:0]        ram_rd_addr;
   logic [FITNESS_BITS-1:0] ram_rd_data;

   logic                        req_accept;
   logic                        req_in_range;
   logic [IDX_W+ENTRY_INDEX_W-1:0]          req_idx_wide;
   logic [FITNESS_BITS+FITNESS_VALUE_W-1:0] req_fit_wide;
   logic [IDX_W-1:0]            data_idx;
   logic [FITNESS_BITS-1:0]     old_fit;
   logic [SUM_W-1:0]            walk_end;
   logic                        point_hit;
   logic                        cur_last;
   logic [CMP_W-1:0]            sum_cmp;
   logic [TOTAL_W-1:0]          total_rep;
   logic [IDX_W+ENTRY_INDEX_W-1:0] sel_wide;

   // Fitness table.
   rws_ram #(
      .WIDTH (FITNESS_BITS),
      .DEPTH (POP_SIZE)
   ) u_fitness_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Requests are taken only while the controller is idle.
   assign req_bus.ready = (state_ff == ST_IDLE);

   // Request decode and datapath terms.
   assign req_accept   = req_bus.valid && req_bus.ready;
   assign req_in_range = 32'(req_bus.entry_index) < 32'(POP_SIZE);
   assign req_idx_wide = {{IDX_W{1'b0}}, req_bus.entry_index};
   assign req_fit_wide = {{FITNESS_BITS{1'b0}}, req_bus.fitness_value};

   // The entry whose data arrives this cycle reads as zero until written.
   assign data_idx  = (state_ff == ST_LOAD) ? addr_ff : cur_ff;
   assign old_fit   = valid_ff[data_idx] ? ram_rd_data : '0;
   assign walk_end  = start_ff + SUM_W'(old_fit);
   assign point_hit = CMP_W'(point_ff) < CMP_W'(walk_end);
   assign cur_last  = (cur_ff == IDX_W'(POP_SIZE - 1));

   // Reported total saturates at the width of the response field.
   assign sum_cmp   = CMP_W'(sum_ff);
   assign total_rep = (sum_cmp > CMP_W'(TOTAL_MAX)) ? TOTAL_MAX : sum_cmp[TOTAL_W-1:0];
   assign sel_wide  = {{ENTRY_INDEX_W{1'b0}}, sel_ff};

   // Next state and outputs of the controller.
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      addr_in      = addr_ff;
      start_in     = start_ff;
      point_in     = point_ff;
      fit_in       = fit_ff;
      sel_in       = sel_ff;
      miss_in      = miss_ff;
      sum_in       = sum_ff;
      zc_in        = zc_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_sel_in   = rsp_sel_ff;
      rsp_miss_in  = rsp_miss_ff;
      rsp_total_in = rsp_total_ff;
      rsp_goal_in  = rsp_goal_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = addr_ff;
      ram_wr_data  = fit_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               sel_in  = '0;
               miss_in = 1'b0;
               if (req_bus.req_type == REQ_SELECT) begin
                  // Start the walk at entry 0.
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = '0;
                  cur_in      = '0;
                  start_in    = '0;
                  point_in    = req_bus.rand_point;
                  state_in    = ST_WALK;
               end else if (req_in_range) begin
                  // Fetch the old value of the entry being replaced.
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = req_idx_wide[IDX_W-1:0];
                  addr_in     = req_idx_wide[IDX_W-1:0];
                  fit_in      = req_fit_wide[FITNESS_BITS-1:0];
                  state_in    = ST_LOAD;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end

         ST_LOAD: begin
            // Replace the entry and keep the total and zero count current.
            ram_wr_en         = 1'b1;
            valid_in[addr_ff] = 1'b1;
            sum_in   = sum_ff - SUM_W'(old_fit) + SUM_W'(fit_ff);
            zc_in    = zc_ff + ZC_W'(fit_ff == '0) - ZC_W'(old_fit == '0);
            state_in = ST_FINISH;
         end

         ST_WALK: begin
            // Every earlier interval ended at or below the point, so only the end is tested.
            if (point_hit) begin
               sel_in   = cur_ff;
               miss_in  = 1'b0;
               state_in = ST_FINISH;
            end else if (cur_last) begin
               sel_in   = IDX_W'(POP_SIZE - 1);
               miss_in  = 1'b1;
               state_in = ST_FINISH;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = cur_ff + IDX_W'(1);
               cur_in      = cur_ff + IDX_W'(1);
               start_in    = walk_end;
            end
         end

         ST_FINISH: begin
            // Hand the result to the response register once it is free.
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_sel_in   = sel_wide[ENTRY_INDEX_W-1:0];
               rsp_miss_in  = miss_ff;
               rsp_total_in = total_rep;
               rsp_goal_in  = (zc_ff != '0);
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         sum_ff       <= '0;
         zc_ff        <= ZC_W'(POP_SIZE);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         sum_ff       <= sum_in;
         zc_ff        <= zc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and response payload.
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      addr_ff      <= addr_in;
      start_ff     <= start_in;
      point_ff     <= point_in;
      fit_ff       <= fit_in;
      sel_ff       <= sel_in;
      miss_ff      <= miss_in;
      rsp_sel_ff   <= rsp_sel_in;
      rsp_miss_ff  <= rsp_miss_in;
      rsp_total_ff <= rsp_total_in;
      rsp_goal_ff  <= rsp_goal_in;
   end

   // Response channel.
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.selected_index = rsp_sel_ff;
   assign rsp_bus.select_miss    = rsp_miss_ff;
   assign rsp_bus.total_fitness  = rsp_total_ff;
   assign rsp_bus.goal_reached   = rsp_goal_ff;

endmodule

`default_nettype wire

// ===== sv/rws_checker.sv =====
// Port-level assertions for the roulette wheel selector and their bind.
`default_nettype none

module rws_checker import rws_pkg::*; #(
   parameter int POP_SIZE = POP_SIZE_DEF
) (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic [ENTRY_INDEX_W-1:0] rsp_selected_index,
   input wire logic                     rsp_select_miss,
   input wire logic [TOTAL_W-1:0]       rsp_total_fitness,
   input wire logic                     rsp_goal_reached
);

   localparam logic [ENTRY_INDEX_W-1:0] LAST_SEL = ENTRY_INDEX_W'((POP_SIZE - 1) % 32);

   logic [1:0] pending_ff, pending_in;

   // Requests accepted whose response beat has not yet been taken.
   always_comb begin
      pending_in = pending_ff + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // No response is offered right after reset.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response offered after reset");

   // A stalled response beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_selected_index)
         && $stable(rsp_select_miss) && $stable(rsp_total_fitness)
         && $stable(rsp_goal_reached))
      else $error("stalled response changed");

   // Every response beat answers an accepted request, and at most two are in flight.
   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || pending_ff != 2'd0) && pending_ff != 2'd3)
      else $error("response without an outstanding request");

   // With no zero entry every individual adds to the total.
   a_goal_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_goal_reached |-> rsp_total_fitness != '0)
      else $error("nonzero table reported a zero total");

   // A miss always names the last individual.
   a_miss_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_select_miss |-> rsp_selected_index == LAST_SEL)
      else $error("miss reported with a wrong index");

endmodule

bind roulette_wheel_selector_top rws_checker #(.POP_SIZE(POP_SIZE)) u_rws_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_selected_index (rsp_bus.selected_index),
   .rsp_select_miss    (rsp_bus.select_miss),
   .rsp_total_fitness  (rsp_bus.total_fitness),
   .rsp_goal_reached   (rsp_bus.goal_reached)
);

`default_nettype wire
